@@ rtl/siq_pkg.sv @@
// Shared types and codes for the staged issue queue.
`default_nettype none

package siq_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned ROOM_W    = 3;
  localparam int unsigned OUT_TAG_W = 6;
  localparam int unsigned KIND_W    = 2;

  // command codes
  localparam logic CMD_FETCH = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_FETCH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ISSUE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_IDLE  = 2'd2;

  // staging buffer entry
  typedef struct packed {
    logic [ADDR_W-1:0] pc;
    logic [WORD_W-1:0] word;
    logic [ADDR_W-1:0] target;
    logic              taken;
  } stage_entry_t;

  // one result transaction
  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic                 fetch_stalled;
    logic                 rob_written;
    logic                 dispatched;
    logic [OUT_TAG_W-1:0] tag;
    logic [ADDR_W-1:0]    pc;
    logic [WORD_W-1:0]    word;
    logic                 taken;
    logic [ADDR_W-1:0]    target;
    logic                 last;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/staged_issue_queue_unit.sv @@
// Staged issue queue: staging buffer, main queue and ROB/dispatch sequencer.
`default_nettype none

// Channel  | valid        | stall        | payload
// ---------+--------------+--------------+---------------------------------------------
// input    | in_valid_i   | in_stall_o   | cmd, fetch_*, rob_room, rob_first_tag,
//          |              |              | dispatch_room
// result   | out_valid_o  | out_stall_i  | kind, fetch_stalled, rob_written, dispatched,
//          |              |              | out_tag, out_pc, out_word, out_taken,
//          |              |              | out_target, last
//
// Sequence: a fetch is handled in the idle state. A tick launches the head read,
//   then makes issue attempts (main queue read port, one entry per cycle while
//   the result register is not stalled), then moves staged entries (stage memory
//   read, main memory write), then clears the staging count and returns to idle.
// Reset: pointers and counts go to zero; the memories are not cleared, since an
//   entry is only read while it is counted as occupied.
// Stalls: out_stall_i freezes the result register and holds an issue attempt in
//   place; in_stall_o is high while a tick is in progress or the result register
//   cannot take a new transaction.

module staged_issue_queue_unit #(
  parameter int unsigned QUEUE_SLOTS = 4,
  parameter int unsigned TAG_BITS    = 6
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,

  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           cmd_i,
  input  wire logic [siq_pkg::ADDR_W-1:0]     fetch_pc_i,
  input  wire logic [siq_pkg::WORD_W-1:0]     fetch_word_i,
  input  wire logic                           fetch_taken_i,
  input  wire logic [siq_pkg::ADDR_W-1:0]     fetch_target_i,
  input  wire logic [siq_pkg::ROOM_W-1:0]     rob_room_i,
  input  wire logic [siq_pkg::OUT_TAG_W-1:0]  rob_first_tag_i,
  input  wire logic [siq_pkg::ROOM_W-1:0]     dispatch_room_i,

  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [siq_pkg::KIND_W-1:0]          kind_o,
  output logic                                fetch_stalled_o,
  output logic                                rob_written_o,
  output logic                                dispatched_o,
  output logic [siq_pkg::OUT_TAG_W-1:0]       out_tag_o,
  output logic [siq_pkg::ADDR_W-1:0]          out_pc_o,
  output logic [siq_pkg::WORD_W-1:0]          out_word_o,
  output logic                                out_taken_o,
  output logic [siq_pkg::ADDR_W-1:0]          out_target_o,
  output logic                                last_o
);

  import siq_pkg::*;

  // count width holds 0..QUEUE_SLOTS; pointer width indexes the queues
  localparam int unsigned CW   = $clog2(QUEUE_SLOTS + 1);
  localparam int unsigned PW   = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int unsigned CMPW = (CW > ROOM_W) ? CW : ROOM_W;
  // tag sum width: wide enough for the input tag and the stored tag
  localparam int unsigned SW   = (TAG_BITS > OUT_TAG_W) ? TAG_BITS : OUT_TAG_W;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_MV_RD = 2'd2;
  localparam logic [1:0] S_MV_WR = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0]   pc;
    logic [WORD_W-1:0]   word;
    logic [ADDR_W-1:0]   target;
    logic                taken;
    logic                in_rob;
    logic [TAG_BITS-1:0] tag;
  } main_entry_t;

  // ---------------------------------------------------------------------------
  // Memories: main queue (circular) and staging buffer (filled from index 0).
  // One write and one registered read per memory per cycle.
  // ---------------------------------------------------------------------------
  main_entry_t  main_mem [QUEUE_SLOTS];
  stage_entry_t stage_mem [QUEUE_SLOTS];

  logic         main_re, main_we;
  logic [PW-1:0] main_raddr, main_waddr;
  main_entry_t  main_wdata, main_rdata_q;

  logic         stage_re, stage_we;
  logic [PW-1:0] stage_raddr, stage_waddr;
  stage_entry_t stage_wdata, stage_rdata_q;

  always_ff @(posedge clk_i) begin
    if (main_we) begin
      main_mem[main_waddr] <= main_wdata;
    end
    if (main_re) begin
      main_rdata_q <= main_mem[main_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_we) begin
      stage_mem[stage_waddr] <= stage_wdata;
    end
    if (stage_re) begin
      stage_rdata_q <= stage_mem[stage_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  logic [1:0]    state_q, state_d;
  logic [PW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] main_cnt_q, main_cnt_d, stage_cnt_q, stage_cnt_d;
  logic [CW-1:0] issued_q, issued_d;       // attempts that dispatched this tick
  logic [CW-1:0] rob_used_q, rob_used_d;   // ROB writes this tick
  logic [CW-1:0] mv_idx_q, mv_idx_d;       // staging entry being moved
  logic          out_valid_q;

  // per-tick room, latched when the tick is accepted
  logic [ROOM_W-1:0]    rob_room_q, disp_room_q;
  logic [OUT_TAG_W-1:0] first_tag_q;

  result_t res_q, res_d;
  logic    res_load;

  logic out_free, in_acc, tick_acc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tick_acc   = in_acc && (cmd_i == CMD_TICK);

  // issue attempt decode on the head entry just read
  logic                need_rob, rob_refuse, disp_stop, last_pop;
  logic [SW-1:0]       tag_sum;
  logic [TAG_BITS-1:0] tag_new, tag_cur;
  logic [SW-1:0]       tag_ext;
  logic [PW-1:0]       head_nxt, tail_nxt;

  assign need_rob   = !main_rdata_q.in_rob;
  assign rob_refuse = need_rob && (CMPW'(rob_used_q) >= CMPW'(rob_room_q));
  assign disp_stop  = CMPW'(issued_q) >= CMPW'(disp_room_q);
  assign tag_sum    = SW'(first_tag_q) + SW'(rob_used_q);
  assign tag_new    = tag_sum[TAG_BITS-1:0];
  assign tag_cur    = need_rob ? tag_new : main_rdata_q.tag;
  assign tag_ext    = SW'(tag_cur);
  // this pop ends the tick when the queue drains or the width is used up
  assign last_pop   = (main_cnt_q == CW'(1)) || (issued_q == CW'(QUEUE_SLOTS - 1));
  assign head_nxt   = (head_q == PW'(QUEUE_SLOTS - 1)) ? '0 : head_q + PW'(1);
  assign tail_nxt   = (tail_q == PW'(QUEUE_SLOTS - 1)) ? '0 : tail_q + PW'(1);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    main_cnt_d  = main_cnt_q;
    stage_cnt_d = stage_cnt_q;
    issued_d    = issued_q;
    rob_used_d  = rob_used_q;
    mv_idx_d    = mv_idx_q;
    res_load    = 1'b0;
    res_d       = '0;
    main_re     = 1'b0;
    main_raddr  = head_q;
    main_we     = 1'b0;
    main_waddr  = head_q;
    main_wdata  = main_rdata_q;
    stage_re    = 1'b0;
    stage_raddr = mv_idx_q[PW-1:0];
    stage_we    = 1'b0;
    stage_waddr = stage_cnt_q[PW-1:0];
    stage_wdata = '{pc: fetch_pc_i, word: fetch_word_i, target: fetch_target_i,
                    taken: fetch_taken_i};

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cmd_i == CMD_FETCH) begin
            res_load   = 1'b1;
            res_d.kind = KIND_FETCH;
            res_d.last = 1'b1;
            if (({1'b0, stage_cnt_q} + {1'b0, main_cnt_q}) >= (CW + 1)'(QUEUE_SLOTS)) begin
              res_d.fetch_stalled = 1'b1;
            end else begin
              stage_we    = 1'b1;
              stage_cnt_d = stage_cnt_q + CW'(1);
            end
          end else begin
            issued_d   = '0;
            rob_used_d = '0;
            mv_idx_d   = '0;
            if (main_cnt_q == '0) begin
              // empty queue: single idle result, then drain staging
              res_load   = 1'b1;
              res_d.kind = KIND_IDLE;
              res_d.last = 1'b1;
              state_d    = S_MV_RD;
            end else begin
              main_re = 1'b1;
              state_d = S_ISSUE;
            end
          end
        end
      end

      S_ISSUE: begin
        if (out_free) begin
          res_load     = 1'b1;
          res_d.kind   = KIND_ISSUE;
          res_d.pc     = main_rdata_q.pc;
          res_d.word   = main_rdata_q.word;
          res_d.taken  = main_rdata_q.taken;
          res_d.target = main_rdata_q.target;
          if (rob_refuse) begin
            res_d.last = 1'b1;
            state_d    = S_MV_RD;
          end else begin
            res_d.rob_written = need_rob;
            res_d.tag         = tag_ext[OUT_TAG_W-1:0];
            if (need_rob) begin
              rob_used_d = rob_used_q + CW'(1);
            end
            if (disp_stop) begin
              // entry stays at the head, keeping its ROB slot
              res_d.last = 1'b1;
              if (need_rob) begin
                main_we           = 1'b1;
                main_waddr        = head_q;
                main_wdata.in_rob = 1'b1;
                main_wdata.tag    = tag_new;
              end
              state_d = S_MV_RD;
            end else begin
              res_d.dispatched = 1'b1;
              res_d.last       = last_pop;
              issued_d         = issued_q + CW'(1);
              head_d           = head_nxt;
              main_cnt_d       = main_cnt_q - CW'(1);
              if (last_pop) begin
                state_d = S_MV_RD;
              end else begin
                main_re    = 1'b1;
                main_raddr = head_nxt;
              end
            end
          end
        end
      end

      S_MV_RD: begin
        if ((mv_idx_q < stage_cnt_q) && (main_cnt_q < CW'(QUEUE_SLOTS))) begin
          stage_re = 1'b1;
          state_d  = S_MV_WR;
        end else begin
          stage_cnt_d = '0;
          state_d     = S_IDLE;
        end
      end

      S_MV_WR: begin
        main_we    = 1'b1;
        main_waddr = tail_q;
        main_wdata = '{pc: stage_rdata_q.pc, word: stage_rdata_q.word,
                       target: stage_rdata_q.target, taken: stage_rdata_q.taken,
                       in_rob: 1'b0, tag: '0};
        tail_d     = tail_nxt;
        main_cnt_d = main_cnt_q + CW'(1);
        mv_idx_d   = mv_idx_q + CW'(1);
        state_d    = S_MV_RD;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      main_cnt_q  <= '0;
      stage_cnt_q <= '0;
      issued_q    <= '0;
      rob_used_q  <= '0;
      mv_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      main_cnt_q  <= main_cnt_d;
      stage_cnt_q <= stage_cnt_d;
      issued_q    <= issued_d;
      rob_used_q  <= rob_used_d;
      mv_idx_q    <= mv_idx_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
    if (tick_acc) begin
      rob_room_q  <= rob_room_i;
      disp_room_q <= dispatch_room_i;
      first_tag_q <= rob_first_tag_i;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = res_q.kind;
  assign fetch_stalled_o = res_q.fetch_stalled;
  assign rob_written_o   = res_q.rob_written;
  assign dispatched_o    = res_q.dispatched;
  assign out_tag_o       = res_q.tag;
  assign out_pc_o        = res_q.pc;
  assign out_word_o      = res_q.word;
  assign out_taken_o     = res_q.taken;
  assign out_target_o    = res_q.target;
  assign last_o          = res_q.last;

endmodule

`default_nettype wire
